// ----- hdl/fhd_pkg.sv -----
package fhd_pkg;

  // One raw byte of the incoming frame.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One result: a path byte, a data byte or the closing frame summary.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [31:0] request_id;
    logic [31:0] frame_id;
    logic [63:0] session_id;
    logic [7:0]  flag_bits;
    logic [7:0]  status_code;
    logic [15:0] path_length;
    logic [2:0]  error_code;
    logic        out_last;
  } out_item_t;

  // Write strobes from the parser into the result queue.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // Result kinds.
  localparam logic [1:0] KindPath    = 2'd0;
  localparam logic [1:0] KindData    = 2'd1;
  localparam logic [1:0] KindSummary = 2'd2;

  // Frame error codes, in the order the checks are applied.
  localparam logic [2:0] ErrOk        = 3'd0;
  localparam logic [2:0] ErrShort     = 3'd1;
  localparam logic [2:0] ErrMagic     = 3'd2;
  localparam logic [2:0] ErrVersion   = 3'd3;
  localparam logic [2:0] ErrSize      = 3'd4;
  localparam logic [2:0] ErrBodyShort = 3'd5;
  localparam logic [2:0] ErrPathLong  = 3'd6;

  // Frame layout.
  localparam logic [31:0] MagicWord   = 32'h666D_7870;
  localparam logic [4:0]  PosVersion  = 5'd4;
  localparam logic [4:0]  PosSize     = 5'd5;
  localparam logic [4:0]  PosRid      = 5'd9;
  localparam logic [4:0]  PosFid      = 5'd13;
  localparam logic [4:0]  PosSsid     = 5'd17;
  localparam logic [4:0]  PosFlags    = 5'd25;
  localparam logic [4:0]  PosStatus   = 5'd26;
  localparam logic [4:0]  PosPathLen  = 5'd27;
  localparam logic [4:0]  FullHdrLen  = 5'd29;
  localparam logic [31:0] HdrLen      = 32'd9;
  localparam logic [31:0] BodyHdrLen  = 32'd20;
  localparam logic [31:0] CountMax    = 32'hFFFF_FFFF;
  localparam logic [7:0]  VersionInit = 8'd1;

endpackage

// ----- hdl/fhd_parser.sv -----
module fhd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  fhd_pkg::in_item_t   item_i,
  input  logic [7:0]          version_i,
  output fhd_pkg::push_t      push_o,
  output fhd_pkg::out_item_t  res0_o,
  output fhd_pkg::out_item_t  res1_o
);

  logic [31:0] count_q, count_d;
  logic        magic_ok_q, magic_ok_d;
  logic        version_ok_q, version_ok_d;
  logic [31:0] size_q, size_d;
  logic [31:0] rid_q, rid_d;
  logic [31:0] fid_q, fid_d;
  logic [63:0] ssid_q, ssid_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  status_q, status_d;
  logic [15:0] path_len_q, path_len_d;

  logic        in_hdr;
  logic [4:0]  pos;
  logic [4:0]  off_size, off_rid, off_fid, off_ssid, off_path;
  logic [7:0]  b;
  logic [7:0]  magic_byte;
  logic        is_payload;
  logic        is_path;
  logic [2:0]  err;
  logic [31:0] body;
  logic [31:0] body_need;

  assign b        = item_i.in_byte;
  assign pos      = count_q[4:0];
  assign in_hdr   = (count_q[31:5] == 27'd0) && (pos < fhd_pkg::FullHdrLen);
  assign off_size = pos - fhd_pkg::PosSize;
  assign off_rid  = pos - fhd_pkg::PosRid;
  assign off_fid  = pos - fhd_pkg::PosFid;
  assign off_ssid = pos - fhd_pkg::PosSsid;
  assign off_path = pos - fhd_pkg::PosPathLen;
  assign is_payload = !in_hdr;

  // Magic byte expected at header positions zero to three.
  assign magic_byte = fhd_pkg::MagicWord[{~pos[1:0], 3'b000} +: 8];

  // A payload byte is a path byte while fewer body bytes than the declared path length
  // followed the header.
  assign is_path = {1'b0, count_q} < (33'(fhd_pkg::FullHdrLen) + 33'(path_len_q));

  // Header field capture; every header byte lands in exactly one field.
  always_comb begin
    magic_ok_d   = magic_ok_q;
    version_ok_d = version_ok_q;
    size_d       = size_q;
    rid_d        = rid_q;
    fid_d        = fid_q;
    ssid_d       = ssid_q;
    flags_d      = flags_q;
    status_d     = status_q;
    path_len_d   = path_len_q;
    if (in_hdr) begin
      if (pos < fhd_pkg::PosVersion) begin
        if (b != magic_byte) begin
          magic_ok_d = 1'b0;
        end
      end else if (pos == fhd_pkg::PosVersion) begin
        version_ok_d = (b == version_i);
      end else if (pos < fhd_pkg::PosRid) begin
        size_d[{off_size[1:0], 3'b000} +: 8] = b;
      end else if (pos < fhd_pkg::PosFid) begin
        rid_d[{off_rid[1:0], 3'b000} +: 8] = b;
      end else if (pos < fhd_pkg::PosSsid) begin
        fid_d[{off_fid[1:0], 3'b000} +: 8] = b;
      end else if (pos < fhd_pkg::PosFlags) begin
        ssid_d[{off_ssid[2:0], 3'b000} +: 8] = b;
      end else if (pos == fhd_pkg::PosFlags) begin
        flags_d = b;
      end else if (pos == fhd_pkg::PosStatus) begin
        status_d = b;
      end else begin
        path_len_d[{off_path[0], 3'b000} +: 8] = b;
      end
    end
  end

  // Byte counter saturates at its maximum.
  assign count_d = (count_q == fhd_pkg::CountMax) ? count_q : count_q + 32'd1;

  // Frame checks on the count that includes the final byte.
  assign body      = count_d - fhd_pkg::HdrLen;
  assign body_need = fhd_pkg::BodyHdrLen + 32'(path_len_d);

  always_comb begin
    if (count_d < fhd_pkg::HdrLen) begin
      err = fhd_pkg::ErrShort;
    end else if (!magic_ok_d) begin
      err = fhd_pkg::ErrMagic;
    end else if (!version_ok_d) begin
      err = fhd_pkg::ErrVersion;
    end else if (size_d != body) begin
      err = fhd_pkg::ErrSize;
    end else if (body < fhd_pkg::BodyHdrLen) begin
      err = fhd_pkg::ErrBodyShort;
    end else if (body_need > body) begin
      err = fhd_pkg::ErrPathLong;
    end else begin
      err = fhd_pkg::ErrOk;
    end
  end

  // Result assembly: a payload byte first, then the summary on the last byte.
  fhd_pkg::out_item_t payload_res, summary_res;

  always_comb begin
    payload_res          = '0;
    payload_res.kind     = is_path ? fhd_pkg::KindPath : fhd_pkg::KindData;
    payload_res.out_byte = b;

    summary_res             = '0;
    summary_res.kind        = fhd_pkg::KindSummary;
    summary_res.request_id  = rid_d;
    summary_res.frame_id    = fid_d;
    summary_res.session_id  = ssid_d;
    summary_res.flag_bits   = flags_d;
    summary_res.status_code = status_d;
    summary_res.path_length = path_len_d;
    summary_res.error_code  = err;
    summary_res.out_last    = 1'b1;
  end

  always_comb begin
    push_o.first  = take_i && (is_payload || item_i.in_last);
    push_o.second = take_i && is_payload && item_i.in_last;
    res0_o        = is_payload ? payload_res : summary_res;
    res1_o        = summary_res;
  end

  // Frame state; the last byte returns everything to its start values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      magic_ok_q   <= 1'b1;
      version_ok_q <= 1'b1;
      size_q       <= '0;
      rid_q        <= '0;
      fid_q        <= '0;
      ssid_q       <= '0;
      flags_q      <= '0;
      status_q     <= '0;
      path_len_q   <= '0;
    end else if (take_i) begin
      if (item_i.in_last) begin
        count_q      <= '0;
        magic_ok_q   <= 1'b1;
        version_ok_q <= 1'b1;
        size_q       <= '0;
        rid_q        <= '0;
        fid_q        <= '0;
        ssid_q       <= '0;
        flags_q      <= '0;
        status_q     <= '0;
        path_len_q   <= '0;
      end else begin
        count_q      <= count_d;
        magic_ok_q   <= magic_ok_d;
        version_ok_q <= version_ok_d;
        size_q       <= size_d;
        rid_q        <= rid_d;
        fid_q        <= fid_d;
        ssid_q       <= ssid_d;
        flags_q      <= flags_d;
        status_q     <= status_d;
        path_len_q   <= path_len_d;
      end
    end
  end

endmodule

// ----- hdl/fhd_queue.sv -----
module fhd_queue #(
  parameter int Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fhd_pkg::push_t      push_i,
  input  fhd_pkg::out_item_t  res0_i,
  input  fhd_pkg::out_item_t  res1_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fhd_pkg::out_item_t  out_item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);

  fhd_pkg::out_item_t mem_q [Depth];

  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  logic [1:0]      n_push;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_next     = ptr_inc(wr_q);
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= RoomMax);
  assign n_push      = {1'b0, push_i.first} + {1'b0, push_i.second};

  // Pointer and fill count update.
  always_comb begin
    wr_d = wr_q;
    if (push_i.second) begin
      wr_d = ptr_inc(wr_next);
    end else if (push_i.first) begin
      wr_d = wr_next;
    end
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Result storage; the second result of a byte goes in the following slot.
  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_i.second) begin
      mem_q[wr_next] <= res1_i;
    end
  end

endmodule

// ----- hdl/frame_header_deframer_core.sv -----
// The results of a transferred byte are registered in the result queue.
// Throughput: one byte per cycle while the queue has room; the final byte of a frame
// that carries payload yields two results, which leave the result queue in order.
// The input stalls only when the result queue has fewer than two free slots.
// Reset (rst_ni low, asynchronous) empties the queue, clears the frame state
// and sets the expected version to one.
module frame_header_deframer_core #(
  parameter int QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fhd_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fhd_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);

  logic [7:0]         version_q;
  logic               take;
  logic               room;
  fhd_pkg::push_t     push;
  fhd_pkg::out_item_t res0, res1;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !room;
  assign take        = in_valid_i && room;

  // Expected version register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= fhd_pkg::VersionInit;
    end else if (cfg_valid_i && cfg_ready_o) begin
      version_q <= cfg_data_i;
    end
  end

  fhd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .item_i    (in_item_i),
    .version_i (version_q),
    .push_o    (push),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  fhd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res0_i      (res0),
    .res1_i      (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
